### rtl/mfhp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfhp_pkg
// Types and constants shared by the MAC frame header parser modules.
// ----------------------------------------------------------------------------
package mfhp_pkg;

  localparam int MAX_FRAME_BYTES = 127;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

  localparam logic [3:0] FLD_CONTROL = 4'd0;
  localparam logic [3:0] FLD_SEQ     = 4'd1;
  localparam logic [3:0] FLD_DPAN    = 4'd2;
  localparam logic [3:0] FLD_DADDR   = 4'd3;
  localparam logic [3:0] FLD_SPAN    = 4'd4;
  localparam logic [3:0] FLD_SADDR   = 4'd5;
  localparam logic [3:0] FLD_WORD0   = 4'd6;
  localparam logic [3:0] FLD_END     = 4'd12;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  field_id;
    logic [63:0] field_value;
    logic [6:0]  header_length;
    logic [6:0]  payload_length;
    logic        parse_status;
    logic        frame_done;
  } out_item_t;

  // Up to two results caused by one input byte
  typedef struct packed {
    out_item_t  res0;
    out_item_t  res1;
    logic [1:0] count;
  } job_t;

endpackage
`default_nettype wire

### rtl/mac_frame_header_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mac_frame_header_parser
// Streaming 802.15.4-style MAC header parser with optional state words.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle. The decoder works on each byte in the cycle
// it is accepted and puts the zero to two items it causes into a four-entry
// queue; the output stage hands out one item per cycle unless field_stall is
// high. Bytes causing at most one item therefore flow at one per cycle; the
// second item of a byte causing two (frame end with a field or compressed
// source PAN) is queued. byte_stall rises only while the queue is full.
module mac_frame_header_parser import mfhp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     byte_valid,
  output logic          byte_stall,
  input  wire in_item_t byte_item,
  output logic          field_valid,
  input  wire logic     field_stall,
  output out_item_t     field_item
);

  logic accept;
  job_t job;
  logic job_valid;
  logic full;
  logic head_valid;
  job_t head;
  logic pop;

  assign byte_stall = full;
  assign accept     = byte_valid && !full;

  mfhp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (byte_item),
    .job       (job),
    .job_valid (job_valid)
  );

  mfhp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (job_valid),
    .push_job   (job),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  mfhp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .valid      (field_valid),
    .stall      (field_stall),
    .item       (field_item)
  );

endmodule
`default_nettype wire

### rtl/mfhp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfhp_front
// Byte-wise header decoder: tracks the current field, assembles field values
// and builds the results caused by each byte.
// ----------------------------------------------------------------------------
module mfhp_front import mfhp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     accept,
  input  wire in_item_t item,
  output job_t          job,
  output logic          job_valid
);

  logic [6:0]  byte_position;
  logic [15:0] control_word;
  logic [3:0]  current_field;
  logic [3:0]  field_byte_count;
  logic [63:0] field_accumulator;
  logic [15:0] saved_dest_pan;

  function automatic logic [3:0] addr_bytes(input logic [1:0] mode);
    unique case (mode)
      2'd2:    addr_bytes = 4'd2;
      2'd3:    addr_bytes = 4'd8;
      default: addr_bytes = 4'd0;
    endcase
  endfunction

  function automatic logic span_pending(input logic [3:0] f, input logic [15:0] cw);
    span_pending = (f == FLD_SPAN) && (cw[15:14] != 2'd0) && cw[6];
  endfunction

  function automatic logic [3:0] field_bytes(input logic [3:0] f, input logic [15:0] cw);
    unique case (f)
      FLD_CONTROL: field_bytes = 4'd2;
      FLD_SEQ:     field_bytes = 4'd1;
      FLD_DPAN:    field_bytes = (cw[11:10] != 2'd0) ? 4'd2 : 4'd0;
      FLD_DADDR:   field_bytes = addr_bytes(cw[11:10]);
      FLD_SPAN:    field_bytes = (cw[15:14] != 2'd0 && !cw[6]) ? 4'd2 : 4'd0;
      FLD_SADDR:   field_bytes = addr_bytes(cw[15:14]);
      default:     field_bytes = (f < FLD_END && cw[9]) ? 4'd2 : 4'd0;
    endcase
  endfunction

  // first field at or after f that takes bytes or a compressed PAN
  function automatic logic [3:0] advance(input logic [3:0] f, input logic [15:0] cw);
    logic [3:0] r;
    r = FLD_END;
    for (int i = int'(FLD_END) - 1; i >= 0; i--) begin
      if (i >= int'(f) &&
          (field_bytes(i[3:0], cw) != 4'd0 || span_pending(i[3:0], cw))) begin
        r = i[3:0];
      end
    end
    return r;
  endfunction

  function automatic logic [6:0] header_bytes(input logic [15:0] cw);
    logic [6:0] h;
    h = 7'd3;
    if (cw[11:10] != 2'd0) h = h + 7'd2;
    h = h + {3'd0, addr_bytes(cw[11:10])};
    if (cw[15:14] != 2'd0 && !cw[6]) h = h + 7'd2;
    h = h + {3'd0, addr_bytes(cw[15:14])};
    if (cw[9]) h = h + 7'd12;
    return h;
  endfunction

  logic [6:0]  bp_next;
  logic        span_now;
  logic [3:0]  cur;
  logic [63:0] acc;
  logic [3:0]  cnt_inc;
  logic        fld_now;
  logic [15:0] control_word_next;
  logic [15:0] saved_dest_pan_next;
  logic [3:0]  current_field_next;
  logic [3:0]  field_byte_count_next;
  logic [63:0] field_accumulator_next;
  logic        complete;
  logic [6:0]  hdr_len;
  logic [6:0]  hl;
  logic        st;
  out_item_t   span_res;
  out_item_t   fld_res;
  out_item_t   end_res;

  always_comb begin
    bp_next = (byte_position < 7'(MAX_FRAME_BYTES)) ? byte_position + 7'd1 : byte_position;
    span_now = span_pending(current_field, control_word);
    cur = span_now ? advance(FLD_SADDR, control_word) : current_field;
    cnt_inc = field_byte_count + 4'd1;
    acc = field_accumulator;
    for (int i = 0; i < 8; i++) begin
      if (field_byte_count[2:0] == i[2:0]) begin
        acc[i*8 +: 8] = acc[i*8 +: 8] | item.data_byte;
      end
    end
    fld_now = 1'b0;
    control_word_next = control_word;
    saved_dest_pan_next = saved_dest_pan;
    current_field_next = cur;
    field_byte_count_next = field_byte_count;
    field_accumulator_next = field_accumulator;
    if (cur < FLD_END) begin
      if (cnt_inc >= field_bytes(cur, control_word)) begin
        fld_now = 1'b1;
        if (cur == FLD_CONTROL) begin
          control_word_next = acc[15:0];
          saved_dest_pan_next = 16'd0;
        end else if (cur == FLD_DPAN) begin
          saved_dest_pan_next = acc[15:0];
        end
        field_accumulator_next = 64'd0;
        field_byte_count_next = 4'd0;
        current_field_next = advance(cur + 4'd1, control_word_next);
      end else begin
        field_accumulator_next = acc;
        field_byte_count_next = cnt_inc;
      end
    end

    complete = (current_field_next >= FLD_END) ||
               (span_pending(current_field_next, control_word_next) &&
                advance(FLD_SADDR, control_word_next) >= FLD_END);
    hdr_len = header_bytes(control_word_next);
    hl = 7'd0;
    st = 1'b1;
    if (complete && current_field_next != FLD_CONTROL && current_field_next != FLD_SEQ &&
        hdr_len <= bp_next) begin
      hl = hdr_len;
      st = 1'b0;
    end

    span_res = '{field_id: FLD_SPAN, field_value: {48'd0, saved_dest_pan},
                 header_length: 7'd0, payload_length: 7'd0,
                 parse_status: 1'b0, frame_done: 1'b0};
    fld_res = '{field_id: cur, field_value: acc, header_length: 7'd0,
                payload_length: 7'd0, parse_status: 1'b0, frame_done: 1'b0};
    end_res = '{field_id: FLD_END, field_value: 64'd0, header_length: hl,
                payload_length: bp_next - hl, parse_status: st, frame_done: 1'b1};

    job.res0 = span_now ? span_res : (fld_now ? fld_res : end_res);
    job.res1 = (span_now && fld_now) ? fld_res : end_res;
    job.count = 2'({1'b0, span_now} + {1'b0, fld_now} + {1'b0, item.last_byte});
    job_valid = accept && (job.count != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 7'd0;
      control_word <= 16'd0;
      current_field <= FLD_CONTROL;
      field_byte_count <= 4'd0;
      field_accumulator <= 64'd0;
      saved_dest_pan <= 16'd0;
    end else if (accept) begin
      if (item.last_byte) begin
        byte_position <= 7'd0;
        control_word <= 16'd0;
        current_field <= FLD_CONTROL;
        field_byte_count <= 4'd0;
        field_accumulator <= 64'd0;
        saved_dest_pan <= 16'd0;
      end else begin
        byte_position <= bp_next;
        control_word <= control_word_next;
        current_field <= current_field_next;
        field_byte_count <= field_byte_count_next;
        field_accumulator <= field_accumulator_next;
        saved_dest_pan <= saved_dest_pan_next;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/mfhp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfhp_queue
// Short FIFO of result groups between the decoder and the output stage.
// ----------------------------------------------------------------------------
module mfhp_queue import mfhp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output logic      full,
  output logic      head_valid,
  output job_t      head
);

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full       = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/mfhp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfhp_back
// Output stage: takes result groups from the queue and hands them out one
// item per cycle while stall is low.
// ----------------------------------------------------------------------------
module mfhp_back import mfhp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  head_valid,
  input  wire job_t  head,
  output logic       pop,
  output logic       valid,
  input  wire logic  stall,
  output out_item_t  item
);

  job_t held;
  logic idx;
  logic take;
  logic at_last;

  assign item    = idx ? held.res1 : held.res0;
  assign take    = valid && !stall;
  assign at_last = (held.count == 2'd2) ? idx : 1'b1;
  assign pop     = head_valid && (!valid || (take && at_last));

  always_ff @(posedge clk) begin
    if (pop) begin
      held <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx <= 1'b0;
    end else if (pop) begin
      valid <= 1'b1;
      idx <= 1'b0;
    end else if (take) begin
      if (at_last) begin
        valid <= 1'b0;
        idx <= 1'b0;
      end else begin
        idx <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the MAC frame header parser.
// ----------------------------------------------------------------------------
// Frames are queued up front: a few hand-built frames, then random ones,
// mostly well formed, some cut inside the header, some random noise and a
// couple running past the maximum frame size. A clocked driver feeds the byte
// stream with random gaps. A clocked monitor decodes every accepted byte in
// its own model of the header layout, holds the field items it expects and
// compares them in order with what the parser emits under random stalls.
module testbench;
  import mfhp_pkg::*;

  localparam int WATCHDOG = 2000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_stall;
  in_item_t  byte_item = '0;
  logic      field_valid;
  logic      field_stall = 1'b0;
  out_item_t field_item;

  mac_frame_header_parser dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .field_valid(field_valid),
    .field_stall(field_stall),
    .field_item (field_item)
  );

  always #1 clk = ~clk;

  in_item_t    rx_bytes[$];
  out_item_t   expected_fields[$];
  int unsigned errors = 0;

  // header decode state
  int unsigned frm_len = 0;
  logic [15:0] fc = '0;
  logic [3:0]  fld = FLD_CONTROL;
  int unsigned fbytes = 0;
  logic [63:0] acc = '0;
  logic [15:0] dpan_copy = '0;

  function automatic int unsigned addr_size(logic [1:0] m);
    return (m == 2'd2) ? 2 : (m == 2'd3) ? 8 : 0;
  endfunction

  function automatic int unsigned hdr_len(logic [15:0] c);
    int unsigned h;
    h = 3 + ((c[11:10] != 0) ? 2 : 0) + addr_size(c[11:10]);
    h += ((c[15:14] != 0 && !c[6]) ? 2 : 0) + addr_size(c[15:14]);
    if (c[9]) h += 12;
    return h;
  endfunction

  function automatic bit span_from_dest(logic [3:0] f);
    return f == FLD_SPAN && fc[15:14] != 0 && fc[6];
  endfunction

  function automatic int unsigned fld_size(logic [3:0] f);
    case (f)
      FLD_CONTROL: return 2;
      FLD_SEQ:     return 1;
      FLD_DPAN:    return (fc[11:10] != 0) ? 2 : 0;
      FLD_DADDR:   return addr_size(fc[11:10]);
      FLD_SPAN:    return (fc[15:14] != 0 && !fc[6]) ? 2 : 0;
      FLD_SADDR:   return addr_size(fc[15:14]);
      default:     return (f < FLD_END && fc[9]) ? 2 : 0;
    endcase
  endfunction

  function automatic logic [3:0] next_field(logic [3:0] f);
    while (f < FLD_END && fld_size(f) == 0 && !span_from_dest(f)) f++;
    return f;
  endfunction

  function automatic out_item_t field_res(logic [3:0] id, logic [63:0] v);
    out_item_t r;
    r = '0;
    r.field_id = id;
    r.field_value = v;
    return r;
  endfunction

  task automatic decode_byte(in_item_t it);
    logic [3:0]  f;
    int unsigned h;
    bit          whole;
    out_item_t   r;
    if (frm_len < MAX_FRAME_BYTES) frm_len++;
    if (span_from_dest(fld)) begin
      expected_fields.push_back(field_res(FLD_SPAN, {48'd0, dpan_copy}));
      fld = next_field(FLD_SADDR);
    end
    if (fld < FLD_END) begin
      acc |= {56'd0, it.data_byte} << (8 * (fbytes % 8));
      fbytes++;
      if (fbytes >= fld_size(fld)) begin
        f = fld;
        expected_fields.push_back(field_res(f, acc));
        if (f == FLD_CONTROL) begin
          fc = acc[15:0];
          dpan_copy = '0;
        end else if (f == FLD_DPAN) begin
          dpan_copy = acc[15:0];
        end
        acc = '0;
        fbytes = 0;
        fld = next_field(f + 4'd1);
      end
    end
    if (it.last_byte) begin
      whole = fld >= FLD_END || (span_from_dest(fld) && next_field(FLD_SADDR) >= FLD_END);
      r = field_res(FLD_END, '0);
      r.parse_status = 1'b1;
      r.frame_done = 1'b1;
      if (whole && fld != FLD_CONTROL && fld != FLD_SEQ) begin
        h = hdr_len(fc);
        if (h <= frm_len) begin
          r.header_length = h[6:0];
          r.parse_status = 1'b0;
        end
      end
      r.payload_length = frm_len[6:0] - r.header_length;
      expected_fields.push_back(r);
      frm_len = 0;
      fc = '0;
      fld = FLD_CONTROL;
      fbytes = 0;
      acc = '0;
      dpan_copy = '0;
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_byte(logic [7:0] b, logic last);
    in_item_t it;
    it.data_byte = b;
    it.last_byte = last;
    rx_bytes.push_back(it);
  endtask

  task automatic add_frame(logic [15:0] c, int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      push_byte((i == 0) ? c[7:0] : (i == 1) ? c[15:8] : 8'($urandom_range(0, 255)),
                i == n - 1);
    end
  endtask

  // driver
  int unsigned src_gap = 0;
  int unsigned src_calm = 0;

  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!byte_valid || !byte_stall) begin
      if (src_gap > 0) begin
        byte_valid <= 1'b0;
        src_gap--;
      end else if (rx_bytes.size() != 0) begin
        byte_valid <= 1'b1;
        byte_item <= rx_bytes.pop_front();
        if (src_calm == 0 && $urandom_range(0, 149) == 0) src_calm = 120;
        if (src_calm > 0) begin
          src_calm--;
          src_gap = 0;
        end else begin
          src_gap = pick_gap();
        end
      end else begin
        byte_valid <= 1'b0;
      end
    end
  end

  // monitor
  int unsigned sink_stall = 0;
  int unsigned sink_calm = 0;
  int unsigned idle_cycles = 0;

  task automatic mismatch(string name, logic [63:0] e, logic [63:0] g);
    errors++;
    if (errors <= 40)
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, e, g);
  endtask

  task automatic check_field(out_item_t g);
    out_item_t e;
    if (expected_fields.size() == 0) begin
      errors++;
      if (errors <= 40)
        $display("%0t: unexpected item, expected none got id %0d value 0x%0h",
                 $time, g.field_id, g.field_value);
      return;
    end
    e = expected_fields.pop_front();
    if (g.field_id !== e.field_id)
      mismatch("field_id", 64'(e.field_id), 64'(g.field_id));
    if (g.field_value !== e.field_value) mismatch("field_value", e.field_value, g.field_value);
    if (g.header_length !== e.header_length)
      mismatch("header_length", 64'(e.header_length), 64'(g.header_length));
    if (g.payload_length !== e.payload_length)
      mismatch("payload_length", 64'(e.payload_length), 64'(g.payload_length));
    if (g.parse_status !== e.parse_status)
      mismatch("parse_status", 64'(e.parse_status), 64'(g.parse_status));
    if (g.frame_done !== e.frame_done)
      mismatch("frame_done", 64'(e.frame_done), 64'(g.frame_done));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      field_stall <= 1'b0;
    end else begin
      if (byte_valid && !byte_stall) decode_byte(byte_item);
      if (field_valid && !field_stall) check_field(field_item);
      if ((byte_valid && !byte_stall) || (field_valid && !field_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG) begin
          $display("%0t: no item moved for %0d cycles", $time, WATCHDOG);
          $display("CHECK FAILED");
          $finish;
        end
      end
      if (sink_stall > 0) begin
        field_stall <= 1'b1;
        sink_stall--;
      end else begin
        field_stall <= 1'b0;
        if (sink_calm == 0 && $urandom_range(0, 199) == 0) sink_calm = 150;
        if (sink_calm > 0) sink_calm--;
        else sink_stall = pick_gap();
      end
    end
  end

  initial begin
    logic [15:0] c;
    int unsigned n;
    int unsigned r;
    int unsigned frames;
    int unsigned n_long;

    // one-byte and two-byte frames
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    // compressed source PAN, frame ends on the byte completing the dest address
    add_frame(16'h4840, 7);
    // same layout, one more byte: compressed PAN and frame end together
    add_frame(16'h4840, 8);
    // compressed source PAN without a destination
    push_byte(8'h40, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'hBB, 1'b0);
    push_byte(8'hCC, 1'b1);

    frames = 0;
    n_long = 0;
    while (rx_bytes.size() < 1650) begin
      c = 16'($urandom);
      r = $urandom_range(0, 99);
      if (frames % 60 == 30 && n_long < 2) begin
        n = $urandom_range(128, 150);
        n_long++;
      end else if (r < 75) begin
        n = hdr_len(c) + (($urandom_range(0, 9) < 7) ? $urandom_range(0, 4)
                                                      : $urandom_range(5, 40));
        if (n > MAX_FRAME_BYTES) n = MAX_FRAME_BYTES;
      end else if (r < 90) begin
        n = $urandom_range(1, hdr_len(c));
      end else begin
        n = $urandom_range(1, 24);
      end
      add_frame(c, n);
      frames++;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (rx_bytes.size() != 0 || byte_valid) @(negedge clk);
    while (expected_fields.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (expected_fields.size() != 0) begin
      errors++;
      $display("%0t: %0d expected items never arrived", $time, expected_fields.size());
    end
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

### mac_frame_header_parser.f
rtl/mfhp_pkg.sv
rtl/mfhp_front.sv
rtl/mfhp_queue.sv
rtl/mfhp_back.sv
rtl/mac_frame_header_parser.sv
tb/testbench.sv
